[src/dofge_pkg.sv]
// ----------------------------------------------------------------------------
// DOF group elimination remap - shared package
// Field widths, command and status codes, controller states and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package dofge_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_NODE_COUNT  = 65536;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned ID_W  = 16;
  localparam int unsigned IDX_W = 18;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned STS_W = 3;

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned OUT_TUSER_W = 4;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ENTRY  = 2'd3;

  localparam logic [STS_W-1:0] STS_ENTRY     = 3'd0;
  localparam logic [STS_W-1:0] STS_ADDED     = 3'd1;
  localparam logic [STS_W-1:0] STS_DUPLICATE = 3'd2;
  localparam logic [STS_W-1:0] STS_FULL      = 3'd3;
  localparam logic [STS_W-1:0] STS_REMOVED   = 3'd4;
  localparam logic [STS_W-1:0] STS_ABSENT    = 3'd5;
  localparam logic [STS_W-1:0] STS_CLEARED   = 3'd6;

  localparam logic [VAL_W-1:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [VAL_W-1:0] ZERO_BITS = 64'h0000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } ctl_t;

endpackage

[src/dofge_ram.sv]
// ----------------------------------------------------------------------------
// DOF group elimination remap - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dofge_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/dofge_ctrl.sv]
// ----------------------------------------------------------------------------
// DOF group elimination remap - controller
// Per word: load, scan all slots, drain, commit; a clear skips scan and drain.
// ----------------------------------------------------------------------------
module dofge_ctrl #(
  parameter int unsigned TABLE_DEPTH = dofge_pkg::DEF_TABLE_DEPTH,
  localparam int unsigned SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dofge_pkg::CMD_W-1:0]   in_cmd,
  input  logic                          commit_ok,
  output dofge_pkg::ctl_t               ctl,
  output logic [SLOT_W-1:0]             rd_addr
);

  dofge_pkg::ctl_state_t state_r, state_nxt;
  logic [SLOT_W-1:0]     ctr_r, ctr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dofge_pkg::ST_IDLE;
      ctr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ctr_nxt    = ctr_r;
    in_tready  = 1'b0;
    ctl.load   = 1'b0;
    ctl.rd_en  = 1'b0;
    ctl.commit = 1'b0;
    case (state_r)
      dofge_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        ctr_nxt   = '0;
        if (in_tvalid) begin
          ctl.load  = 1'b1;
          state_nxt = (in_cmd == dofge_pkg::CMD_CLEAR) ? dofge_pkg::ST_FINISH
                                                       : dofge_pkg::ST_SCAN;
        end
      end
      dofge_pkg::ST_SCAN: begin
        ctl.rd_en = 1'b1;
        if (ctr_r == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_nxt = dofge_pkg::ST_DRAIN;
        end else begin
          ctr_nxt = ctr_r + 1'b1;
        end
      end
      dofge_pkg::ST_DRAIN: begin
        state_nxt = dofge_pkg::ST_FINISH;
      end
      dofge_pkg::ST_FINISH: begin
        if (commit_ok) begin
          ctl.commit = 1'b1;
          state_nxt  = dofge_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dofge_pkg::ST_IDLE;
      end
    endcase
  end

  assign rd_addr = ctr_r;

endmodule

[src/dofge_dp.sv]
// ----------------------------------------------------------------------------
// DOF group elimination remap - datapath
// Word registers, per-slot group compares and rank counters, valid bits,
// mode register and the output register.
// ----------------------------------------------------------------------------
module dofge_dp #(
  parameter int unsigned TABLE_DEPTH = dofge_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned NODE_COUNT  = dofge_pkg::DEF_NODE_COUNT,
  localparam int unsigned SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dofge_pkg::ctl_t                     ctl,
  output logic                                commit_ok,
  input  logic [SLOT_W-1:0]                   rd_addr,
  input  logic                                cfg_valid,
  input  logic                                cfg_data,
  input  logic [dofge_pkg::CMD_W-1:0]         in_cmd,
  input  logic [dofge_pkg::ID_W-1:0]          in_node_id,
  input  logic [dofge_pkg::IDX_W-1:0]         in_entry_row,
  input  logic [dofge_pkg::IDX_W-1:0]         in_entry_col,
  input  logic                                in_entry_is_vector,
  input  logic [dofge_pkg::VAL_W-1:0]         in_entry_value,
  output logic                                ram_we,
  output logic [SLOT_W-1:0]                   ram_waddr,
  output logic [dofge_pkg::ID_W-1:0]          ram_wdata,
  input  logic [dofge_pkg::ID_W-1:0]          ram_rdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dofge_pkg::STS_W-1:0]         out_status,
  output logic [dofge_pkg::IDX_W-1:0]         out_row,
  output logic [dofge_pkg::IDX_W-1:0]         out_col,
  output logic                                out_is_vector,
  output logic [dofge_pkg::VAL_W-1:0]         out_value
);

  localparam int unsigned IW = dofge_pkg::IDX_W;

  logic [dofge_pkg::CMD_W-1:0] cmd_r;
  logic [dofge_pkg::ID_W-1:0]  id_r;
  logic [IW-1:0]               row_r, col_r;
  logic                        vec_r;
  logic [dofge_pkg::VAL_W-1:0] val_r;

  logic                        mode_r;
  logic [TABLE_DEPTH-1:0]      valid_r, valid_nxt;
  logic                        cmp_en_r;
  logic [SLOT_W-1:0]           slot_q_r;

  logic                        row_hit_r, row_hit_nxt;
  logic                        col_hit_r, col_hit_nxt;
  logic [CNT_W-1:0]            row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0]            col_cnt_r, col_cnt_nxt;
  logic                        found_r, found_nxt;
  logic [SLOT_W-1:0]           found_slot_r, found_slot_nxt;
  logic                        free_r, free_nxt;
  logic [SLOT_W-1:0]           free_slot_r, free_slot_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [dofge_pkg::STS_W-1:0] out_status_r;
  logic [IW-1:0]               out_row_r, out_col_r;
  logic                        out_vec_r;
  logic [dofge_pkg::VAL_W-1:0] out_value_r;

  logic                        slot_live;
  logic [IW-1:0]               base;
  logic [IW:0]                 base_top;
  logic                        in_range, add_ok, rm_ok, hit, has_result;
  logic [dofge_pkg::STS_W-1:0] sts;
  logic [IW-1:0]               res_row, res_col;
  logic [dofge_pkg::VAL_W-1:0] res_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      valid_r     <= '0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      valid_r     <= valid_nxt;
      cmp_en_r    <= ctl.rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      id_r  <= in_node_id;
      row_r <= in_entry_row;
      col_r <= in_entry_is_vector ? '0 : in_entry_col;
      vec_r <= in_entry_is_vector;
      val_r <= in_entry_value;
    end
    slot_q_r     <= rd_addr;
    row_hit_r    <= row_hit_nxt;
    col_hit_r    <= col_hit_nxt;
    row_cnt_r    <= row_cnt_nxt;
    col_cnt_r    <= col_cnt_nxt;
    found_r      <= found_nxt;
    found_slot_r <= found_slot_nxt;
    free_r       <= free_nxt;
    free_slot_r  <= free_slot_nxt;
    if (ctl.commit && has_result) begin
      out_status_r <= sts;
      out_row_r    <= res_row;
      out_col_r    <= res_col;
      out_vec_r    <= (cmd_r == dofge_pkg::CMD_ENTRY) ? vec_r : 1'b0;
      out_value_r  <= res_val;
    end
  end

  // slot compare: group of id d spans 3d .. 3d+2
  always_comb begin
    slot_live      = cmp_en_r && valid_r[slot_q_r];
    base           = IW'({ram_rdata, 1'b0}) + IW'(ram_rdata);
    base_top       = {1'b0, base} + (IW+1)'(3);
    row_hit_nxt    = row_hit_r;
    col_hit_nxt    = col_hit_r;
    row_cnt_nxt    = row_cnt_r;
    col_cnt_nxt    = col_cnt_r;
    found_nxt      = found_r;
    found_slot_nxt = found_slot_r;
    free_nxt       = free_r;
    free_slot_nxt  = free_slot_r;
    if (ctl.load) begin
      row_hit_nxt = 1'b0;
      col_hit_nxt = 1'b0;
      row_cnt_nxt = '0;
      col_cnt_nxt = '0;
      found_nxt   = 1'b0;
      free_nxt    = 1'b0;
    end else if (slot_live) begin
      if (row_r >= base && {1'b0, row_r} < base_top) begin
        row_hit_nxt = 1'b1;
      end
      if (col_r >= base && {1'b0, col_r} < base_top) begin
        col_hit_nxt = 1'b1;
      end
      if ({1'b0, base} + (IW+1)'(2) < {1'b0, row_r}) begin
        row_cnt_nxt = row_cnt_r + 1'b1;
      end
      if ({1'b0, base} + (IW+1)'(2) < {1'b0, col_r}) begin
        col_cnt_nxt = col_cnt_r + 1'b1;
      end
      if (ram_rdata == id_r) begin
        found_nxt      = 1'b1;
        found_slot_nxt = slot_q_r;
      end
    end else if (cmp_en_r && !free_r) begin
      free_nxt      = 1'b1;
      free_slot_nxt = slot_q_r;
    end
  end

  always_comb begin
    in_range   = 32'(id_r) < 32'(NODE_COUNT);
    add_ok     = in_range && !found_r && free_r;
    rm_ok      = in_range && found_r;
    hit        = row_hit_r || (!vec_r && col_hit_r);
    has_result = !(cmd_r == dofge_pkg::CMD_ENTRY && !mode_r && hit);
    sts        = dofge_pkg::STS_ENTRY;
    res_row    = '0;
    res_col    = '0;
    res_val    = dofge_pkg::ZERO_BITS;
    case (cmd_r)
      dofge_pkg::CMD_ADD: begin
        if (!in_range) begin
          sts = dofge_pkg::STS_ABSENT;
        end else if (found_r) begin
          sts = dofge_pkg::STS_DUPLICATE;
        end else if (!free_r) begin
          sts = dofge_pkg::STS_FULL;
        end else begin
          sts = dofge_pkg::STS_ADDED;
        end
      end
      dofge_pkg::CMD_REMOVE: begin
        sts = rm_ok ? dofge_pkg::STS_REMOVED : dofge_pkg::STS_ABSENT;
      end
      dofge_pkg::CMD_CLEAR: begin
        sts = dofge_pkg::STS_CLEARED;
      end
      dofge_pkg::CMD_ENTRY: begin
        sts = dofge_pkg::STS_ENTRY;
        if (!mode_r) begin
          res_row = row_r - (IW'({row_cnt_r, 1'b0}) + IW'(row_cnt_r));
          res_col = col_r - (IW'({col_cnt_r, 1'b0}) + IW'(col_cnt_r));
          res_val = val_r;
        end else begin
          res_row = row_r;
          res_col = col_r;
          if (hit) begin
            res_val = (!vec_r && row_r == col_r) ? dofge_pkg::ONE_BITS
                                                 : dofge_pkg::ZERO_BITS;
          end else begin
            res_val = val_r;
          end
        end
      end
      default: begin
        sts = dofge_pkg::STS_ENTRY;
      end
    endcase
  end

  always_comb begin
    commit_ok = !has_result || !out_valid_r || out_tready;
    valid_nxt = valid_r;
    ram_we    = 1'b0;
    if (ctl.commit) begin
      case (cmd_r)
        dofge_pkg::CMD_ADD: begin
          if (add_ok) begin
            valid_nxt[free_slot_r] = 1'b1;
            ram_we                 = 1'b1;
          end
        end
        dofge_pkg::CMD_REMOVE: begin
          if (rm_ok) begin
            valid_nxt[found_slot_r] = 1'b0;
          end
        end
        dofge_pkg::CMD_CLEAR: begin
          valid_nxt = '0;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
    if (ctl.commit && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign ram_waddr     = free_slot_r;
  assign ram_wdata     = id_r;
  assign out_tvalid    = out_valid_r;
  assign out_status    = out_status_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_is_vector = out_vec_r;
  assign out_value     = out_value_r;

endmodule

[src/dof_group_elimination_remap_top.sv]
// ----------------------------------------------------------------------------
// DOF group elimination remap - top level
// Holds a table of constrained node ids; drops or overwrites sparse matrix
// and vector entries on a held node's three rows; remove mode remaps others.
//
// in_*  : one word per command (add, remove, clear) or matrix/vector entry.
// out_* : at most one word back per input word; a dropped entry gives none.
// cfg_* : elimination mode, 0 remove rows/cols, 1 overwrite in place.
// Each add, remove or entry scans every table slot through the id RAM,
// one slot per cycle, then drains the last compare and commits its result;
// a clear skips the scan and the drain. A new input word is accepted only
// once the previous word has committed.
// The output register holds a finished word while the next input word is
// accepted and processed; a stalled receiver holds the block only when a
// new result is ready and the output register is still full.
// Reset empties the table and sets remove mode; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dof_group_elimination_remap_top #(
  parameter int unsigned TABLE_DEPTH = dofge_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned NODE_COUNT  = dofge_pkg::DEF_NODE_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // node_id[15:0], entry_row[33:16], entry_col[51:34], entry_value[115:52]
  input  logic [dofge_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cmd[1:0], entry_is_vector[2]
  input  logic [dofge_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_row[17:0], out_col[35:18], out_value[99:36]
  output logic [dofge_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status[2:0], out_is_vector[3]
  output logic [dofge_pkg::OUT_TUSER_W-1:0]    out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_data
);

  localparam int unsigned SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  dofge_pkg::ctl_t                  ctl;
  logic                             commit_ok;
  logic [SLOT_W-1:0]                rd_addr;
  logic                             ram_we;
  logic [SLOT_W-1:0]                ram_waddr;
  logic [dofge_pkg::ID_W-1:0]       ram_wdata, ram_rdata;
  logic [dofge_pkg::STS_W-1:0]      out_status;
  logic [dofge_pkg::IDX_W-1:0]      out_row, out_col;
  logic                             out_is_vector;
  logic [dofge_pkg::VAL_W-1:0]      out_value;

  assign cfg_ready = 1'b1;

  dofge_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser[1:0]),
    .commit_ok (commit_ok),
    .ctl       (ctl),
    .rd_addr   (rd_addr)
  );

  dofge_ram #(
    .WIDTH (dofge_pkg::ID_W),
    .DEPTH (TABLE_DEPTH)
  ) u_id_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  dofge_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NODE_COUNT  (NODE_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .commit_ok          (commit_ok),
    .rd_addr            (rd_addr),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .in_cmd             (in_tuser[1:0]),
    .in_node_id         (in_tdata[15:0]),
    .in_entry_row       (in_tdata[33:16]),
    .in_entry_col       (in_tdata[51:34]),
    .in_entry_is_vector (in_tuser[2]),
    .in_entry_value     (in_tdata[115:52]),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_rdata          (ram_rdata),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_status         (out_status),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_is_vector      (out_is_vector),
    .out_value          (out_value)
  );

  assign out_tdata = {4'b0, out_value, out_col, out_row};
  assign out_tuser = {out_is_vector, out_status};

endmodule

[src/dofge_chk.sv]
// ----------------------------------------------------------------------------
// DOF group elimination remap - port checker
// Watch the top level ports over time and flag handshake and sequencing slips.
// ----------------------------------------------------------------------------
module dofge_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [dofge_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output word present after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous word in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:0] <= dofge_pkg::STS_CLEARED)
    else $error("undefined status code on output");

endmodule

bind dof_group_elimination_remap_top dofge_chk u_dofge_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser)
);

[dv/dof_group_elimination_remap_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DOF group elimination remap - block-level test
// Streams node-table commands and sparse matrix/vector entries into the
// block under random source and sink stalls, in both elimination modes.
// A shadow table predicts every status word and remapped or overwritten
// entry; the scoreboard compares each result word field by field in order.
// ----------------------------------------------------------------------------
module dof_group_elimination_remap_top_test;

  localparam int unsigned DEPTH   = dofge_pkg::DEF_TABLE_DEPTH;
  localparam int unsigned IDX_TOP = 196607;

  typedef struct {
    logic [dofge_pkg::STS_W-1:0] status;
    logic [dofge_pkg::IDX_W-1:0] row;
    logic [dofge_pkg::IDX_W-1:0] col;
    logic                        vec;
    logic [dofge_pkg::VAL_W-1:0] value;
  } remap_word_t;

  typedef enum int {KIND_FILL, KIND_BUILD, KIND_CHURN, KIND_STREAM} phase_kind_t;

  class remap_scoreboard;
    int unsigned held[DEPTH];
    bit          used[DEPTH];
    bit          mode;
    int          fails;
    remap_word_t expected_words[$];

    function bit in_group(int unsigned idx);
      for (int s = 0; s < DEPTH; s++)
        if (used[s] && idx >= 3 * held[s] && idx < 3 * held[s] + 3) return 1'b1;
      return 1'b0;
    endfunction

    function int unsigned groups_below(int unsigned idx);
      int unsigned n;
      n = 0;
      for (int s = 0; s < DEPTH; s++)
        if (used[s] && 3 * held[s] + 2 < idx) n++;
      return n;
    endfunction

    function int find_slot(int unsigned id);
      for (int s = 0; s < DEPTH; s++)
        if (used[s] && held[s] == id) return s;
      return -1;
    endfunction

    function int held_pick();
      int slots[$];
      for (int s = 0; s < DEPTH; s++)
        if (used[s]) slots = {slots, s};
      if (slots.size() == 0) return -1;
      return int'(held[slots[$urandom_range(0, slots.size() - 1)]]);
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction

    function void note_word(logic [dofge_pkg::CMD_W-1:0] cmd,
                            logic [dofge_pkg::ID_W-1:0] id,
                            logic [dofge_pkg::IDX_W-1:0] row,
                            logic [dofge_pkg::IDX_W-1:0] col,
                            logic vec, logic [dofge_pkg::VAL_W-1:0] value);
      remap_word_t w;
      int          slot;
      int unsigned r;
      int unsigned c;
      bit          hit;
      w = '{status: dofge_pkg::STS_ENTRY, row: '0, col: '0, vec: 1'b0, value: '0};
      case (cmd)
        dofge_pkg::CMD_ADD: begin
          if (find_slot(32'(id)) >= 0) begin
            w.status = dofge_pkg::STS_DUPLICATE;
          end else begin
            w.status = dofge_pkg::STS_FULL;
            for (int s = 0; s < DEPTH; s++)
              if (!used[s]) begin
                used[s]  = 1'b1;
                held[s]  = 32'(id);
                w.status = dofge_pkg::STS_ADDED;
                break;
              end
          end
        end
        dofge_pkg::CMD_REMOVE: begin
          slot = find_slot(32'(id));
          if (slot >= 0) begin
            used[slot] = 1'b0;
            w.status   = dofge_pkg::STS_REMOVED;
          end else begin
            w.status = dofge_pkg::STS_ABSENT;
          end
        end
        dofge_pkg::CMD_CLEAR: begin
          used     = '{default: 1'b0};
          w.status = dofge_pkg::STS_CLEARED;
        end
        default: begin
          r   = 32'(row);
          c   = vec ? 32'd0 : 32'(col);
          hit = in_group(r) || (!vec && in_group(c));
          if (!mode) begin
            if (hit) return;
            r -= 3 * groups_below(r);
            if (!vec) c -= 3 * groups_below(c);
          end else if (hit) begin
            value = (!vec && r == c) ? dofge_pkg::ONE_BITS : dofge_pkg::ZERO_BITS;
          end
          w.row   = r[dofge_pkg::IDX_W-1:0];
          w.col   = c[dofge_pkg::IDX_W-1:0];
          w.vec   = vec;
          w.value = value;
        end
      endcase
      expected_words = {expected_words, w};
    endfunction

    function void check_word(logic [dofge_pkg::OUT_TDATA_W-1:0] tdata,
                             logic [dofge_pkg::OUT_TUSER_W-1:0] tuser);
      remap_word_t w;
      if (expected_words.size() == 0) begin
        $error("status: expected no word, actual %0d", tuser[2:0]);
        fails++;
        return;
      end
      w = expected_words.pop_front();
      if (tuser[2:0] !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, tuser[2:0]);
        fails++;
      end
      if (tdata[17:0] !== w.row) begin
        $error("out_row: expected %0d, actual %0d", w.row, tdata[17:0]);
        fails++;
      end
      if (tdata[35:18] !== w.col) begin
        $error("out_col: expected %0d, actual %0d", w.col, tdata[35:18]);
        fails++;
      end
      if (tuser[3] !== w.vec) begin
        $error("out_is_vector: expected %0d, actual %0d", w.vec, tuser[3]);
        fails++;
      end
      if (tdata[99:36] !== w.value) begin
        $error("out_value: expected %h, actual %h", w.value, tdata[99:36]);
        fails++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [dofge_pkg::IN_TDATA_W-1:0]    in_tdata;
  logic [dofge_pkg::IN_TUSER_W-1:0]    in_tuser;
  logic                                out_tvalid;
  logic                                out_tready;
  logic [dofge_pkg::OUT_TDATA_W-1:0]   out_tdata;
  logic [dofge_pkg::OUT_TUSER_W-1:0]   out_tuser;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic                                cfg_data;

  remap_scoreboard sb = new();
  bit              send_calm;

  dof_group_elimination_remap_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic send_word(input logic [dofge_pkg::CMD_W-1:0] cmd,
                           input logic [dofge_pkg::ID_W-1:0] id,
                           input logic [dofge_pkg::IDX_W-1:0] row,
                           input logic [dofge_pkg::IDX_W-1:0] col,
                           input logic vec, input logic [dofge_pkg::VAL_W-1:0] value);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, value, col, row, id};
    in_tuser  <= {vec, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_word(cmd, id, row, col, vec, value);
  endtask

  // hold the source until every result is back and the last scan has ended
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic set_mode(input bit m);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.mode = m;
  endtask

  function automatic logic [dofge_pkg::IDX_W-1:0] aim_index();
    int          h;
    int          v;
    int unsigned choice;
    choice = $urandom_range(0, 15);
    if (choice < 9) begin
      h = sb.held_pick();
      if (h >= 0) begin
        v = 3 * h + int'($urandom_range(0, 8)) - 3;
        if (v < 0) v = 0;
        if (v > int'(IDX_TOP)) v = int'(IDX_TOP);
        return v[dofge_pkg::IDX_W-1:0];
      end
    end
    if (choice == 9) return '0;
    if (choice == 10) return 18'(IDX_TOP);
    return 18'($urandom_range(0, IDX_TOP));
  endfunction

  task automatic random_word(input phase_kind_t kind,
                             input logic [dofge_pkg::ID_W-1:0] base,
                             input int unsigned span);
    int unsigned                 pick;
    int                          h;
    logic [dofge_pkg::CMD_W-1:0] cmd;
    logic [dofge_pkg::ID_W-1:0]  id;
    pick = $urandom_range(0, 99);
    case (kind)
      KIND_FILL:  cmd = pick < 85 ? dofge_pkg::CMD_ADD :
                        pick < 88 ? dofge_pkg::CMD_REMOVE : dofge_pkg::CMD_ENTRY;
      KIND_BUILD: cmd = pick < 50 ? dofge_pkg::CMD_ADD :
                        pick < 55 ? dofge_pkg::CMD_REMOVE : dofge_pkg::CMD_ENTRY;
      KIND_CHURN: cmd = pick < 30 ? dofge_pkg::CMD_ADD :
                        pick < 60 ? dofge_pkg::CMD_REMOVE :
                        pick < 63 ? dofge_pkg::CMD_CLEAR : dofge_pkg::CMD_ENTRY;
      default:    cmd = pick < 4 ? dofge_pkg::CMD_ADD :
                        pick < 8 ? dofge_pkg::CMD_REMOVE :
                        pick < 9 ? dofge_pkg::CMD_CLEAR : dofge_pkg::CMD_ENTRY;
    endcase
    if ($urandom_range(0, 7) == 0) id = 16'($urandom_range(0, 65535));
    else id = 16'(32'(base) + $urandom_range(0, span));
    if (cmd == dofge_pkg::CMD_REMOVE && $urandom_range(0, 1) == 1) begin
      h = sb.held_pick();
      if (h >= 0) id = 16'(h);
    end
    send_word(cmd, id, aim_index(), aim_index(), $urandom_range(0, 3) == 0,
              {$urandom, $urandom});
  endtask

  initial begin
    int unsigned                sent;
    int unsigned                span;
    int unsigned                len;
    bit                         m;
    phase_kind_t                kind;
    logic [dofge_pkg::ID_W-1:0] base;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    rst_n     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mode(1'b0);
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'(IDX_TOP), 18'd0, 1'b0, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'hFFFF, 18'd77, 18'h3FFFF, 1'b1, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ADD, 16'd0, 18'd0, 18'd0, 1'b0, 64'd0);
    send_word(dofge_pkg::CMD_ADD, 16'hFFFF, 18'h3FFFF, 18'h3FFFF, 1'b1, '1);
    send_word(dofge_pkg::CMD_ADD, 16'd0, 18'd0, 18'd0, 1'b0, 64'd0);
    send_word(dofge_pkg::CMD_ADD, 16'd100, 18'd0, 18'd0, 1'b0, 64'd0);
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd1, 18'd40, 1'b0, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd5, 18'(IDX_TOP), 1'b0, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd3, 18'd299, 1'b0, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd303, 18'd196604, 1'b0, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd196604, 18'd7, 1'b1, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd2, 18'd500, 1'b1, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_REMOVE, 16'd100, 18'd0, 18'd0, 1'b0, 64'd0);
    send_word(dofge_pkg::CMD_REMOVE, 16'd100, 18'd0, 18'd0, 1'b0, 64'd0);
    send_word(dofge_pkg::CMD_REMOVE, 16'd42, 18'd0, 18'd0, 1'b0, 64'd0);
    set_mode(1'b1);
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd0, 18'd0, 1'b0, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd1, 18'd2, 1'b0, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd196605, 18'd196605, 1'b0,
              {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd196606, 18'd196606, 1'b1,
              {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd10, 18'd11, 1'b0, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd3, 18'd1, 1'b1, {$urandom, $urandom});
    send_word(dofge_pkg::CMD_CLEAR, 16'hA5A5, 18'h2AAAA, 18'h15555, 1'b1,
              {$urandom, $urandom});
    send_word(dofge_pkg::CMD_ENTRY, 16'd0, 18'd0, 18'd0, 1'b0, {$urandom, $urandom});

    sent = 0;
    while (sent < 1700) begin
      m = 1'($urandom_range(0, 1));
      if (m != sb.mode || $urandom_range(0, 3) == 0) set_mode(m);
      else if ($urandom_range(0, 1) == 1) settle();
      kind = phase_kind_t'($urandom_range(0, 3));
      base = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'd90 : 16'($urandom_range(0, 65535));
      span = (kind == KIND_FILL) ? 90 : $urandom_range(4, 150);
      len  = (kind == KIND_FILL) ? 200 : $urandom_range(30, 150);
      repeat (len) begin
        random_word(kind, base, span);
        sent++;
      end
    end

    settle();
    if (sb.fails == 0 && sb.outstanding() == 0)
      $display("[dof_group_elimination_remap_top] OK");
    else
      $display("[dof_group_elimination_remap_top] ERROR");
    $finish;
  end

  initial begin
    int unsigned stall;
    bit          calm;
    out_tready <= 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_word(out_tdata, out_tuser);
    end
  end

  initial begin
    #15_000_000;
    $display("[dof_group_elimination_remap_top] ERROR");
    $finish;
  end

endmodule
